[rtl/assert_macros.svh]
// Assertion macros for the packet deframer RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deframer assertion failed");

`define SPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("deframer assertion failed");

`else

`define SPD_ASSERT(lbl, clk, rst_n, prop)

`define SPD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/spd_pkg.sv]
// Types and constants for the sync packet deframer.
// No dependencies; imported by sync_packet_deframer.
package spd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(1024);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LENLO = 3'd3,
    PH_LENHI = 3'd4,
    PH_DATA  = 3'd5,
    PH_CKLO  = 3'd6,
    PH_CKHI  = 3'd7
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BADSUM  = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LEN     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  msg_id;
    logic [LEN_W-1:0]   index_or_length;
  } result_t;

endpackage

[rtl/sync_packet_deframer.sv]
// Sync packet deframer top level: sync hunt, header, payload, Fletcher check.
// Depends on spd_pkg and assert_macros.svh.
//
//   channel | dir | handshake          | beat
//   in_     | in  | in_valid/in_stall   | in_rx_byte
//   out_    | out | out_valid/out_stall | kind, data_byte, msg_id, index_or_length
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// One byte per cycle unless stalled: each beat updates the phase and sums when taken,
// and its result (if any) appears in the output register on the next cycle.
// The output register is the only buffer; in_stall rises while it is full and stalled.
// rst_n is synchronous, active low; cfg_ready is always high.
`include "assert_macros.svh"

module sync_packet_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spd_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spd_pkg::KIND_W-1:0]    out_kind,
  output logic [spd_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [spd_pkg::BYTE_W-1:0]    out_msg_id,
  output logic [spd_pkg::LEN_W-1:0]     out_index_or_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import spd_pkg::*;

  logic [BYTE_W-1:0] sync_first_r, sync_second_r;
  logic [LEN_W-1:0]  max_len_r;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] frame_id_r, frame_id_nxt;
  logic [BYTE_W-1:0] len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]  pay_len_r, pay_len_nxt;
  logic [LEN_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [BYTE_W-1:0] sum_a_r, sum_a_nxt;
  logic [BYTE_W-1:0] sum_b_r, sum_b_nxt;
  logic [BYTE_W-1:0] ck_lo_r, ck_lo_nxt;

  logic              out_valid_r;
  result_t           res_r, res_nxt;
  logic              res_vld;

  logic              acc;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] fold_a, fold_b;
  logic [LEN_W-1:0]  hdr_len;
  logic [LEN_W-1:0]  cnt_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign acc       = in_valid & ~in_stall;
  assign b         = in_rx_byte;

  assign fold_a  = sum_a_r + b;
  assign fold_b  = sum_b_r + fold_a;
  assign hdr_len = {b, len_lo_r};
  assign cnt_inc = byte_cnt_r + LEN_W'(1);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SYNC1: begin
        if (b == sync_first_r) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == sync_second_r)     phase_nxt = PH_ID;
        else if (b != sync_first_r) phase_nxt = PH_SYNC1;
      end
      PH_ID:    phase_nxt = PH_LENLO;
      PH_LENLO: phase_nxt = PH_LENHI;
      PH_LENHI: begin
        if (hdr_len > max_len_r)          phase_nxt = PH_SYNC1;
        else if (hdr_len == '0)           phase_nxt = PH_CKLO;
        else                              phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (cnt_inc >= pay_len_r) phase_nxt = PH_CKLO;
      end
      PH_CKLO:  phase_nxt = PH_CKHI;
      PH_CKHI:  phase_nxt = PH_SYNC1;
      default:  phase_nxt = PH_SYNC1;
    endcase
  end

  // datapath and result
  always_comb begin
    frame_id_nxt = frame_id_r;
    len_lo_nxt   = len_lo_r;
    pay_len_nxt  = pay_len_r;
    byte_cnt_nxt = byte_cnt_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    ck_lo_nxt    = ck_lo_r;
    res_vld      = 1'b0;
    res_nxt      = '{kind: KIND_DATA, data_byte: '0, msg_id: frame_id_r,
                     index_or_length: pay_len_r};
    case (phase_r)
      PH_SYNC1: byte_cnt_nxt = '0;
      PH_SYNC2: ;
      PH_ID: begin
        frame_id_nxt = b;
        sum_a_nxt    = b;
        sum_b_nxt    = b;
      end
      PH_LENLO: begin
        len_lo_nxt = b;
        sum_a_nxt  = fold_a;
        sum_b_nxt  = fold_b;
      end
      PH_LENHI: begin
        sum_a_nxt    = fold_a;
        sum_b_nxt    = fold_b;
        pay_len_nxt  = hdr_len;
        byte_cnt_nxt = '0;
        if (hdr_len > max_len_r) begin
          res_vld                 = 1'b1;
          res_nxt.kind            = KIND_TOOLONG;
          res_nxt.index_or_length = hdr_len;
        end
      end
      PH_DATA: begin
        sum_a_nxt               = fold_a;
        sum_b_nxt               = fold_b;
        byte_cnt_nxt            = cnt_inc;
        res_vld                 = 1'b1;
        res_nxt.kind            = KIND_DATA;
        res_nxt.data_byte       = b;
        res_nxt.index_or_length = byte_cnt_r;
      end
      PH_CKLO: ck_lo_nxt = b;
      PH_CKHI: begin
        res_vld      = 1'b1;
        res_nxt.kind = ((ck_lo_r == sum_a_r) && (b == sum_b_r)) ? KIND_GOOD : KIND_BADSUM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= '0;
      sync_second_r <= '0;
      max_len_r     <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[BYTE_W-1:0];
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata[BYTE_W-1:0];
        REG_MAX_LEN:     max_len_r     <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SYNC1;
      frame_id_r <= '0;
      len_lo_r   <= '0;
      pay_len_r  <= '0;
      byte_cnt_r <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      ck_lo_r    <= '0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      frame_id_r <= frame_id_nxt;
      len_lo_r   <= len_lo_nxt;
      pay_len_r  <= pay_len_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      ck_lo_r    <= ck_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = res_r.kind;
  assign out_data_byte       = res_r.data_byte;
  assign out_msg_id          = res_r.msg_id;
  assign out_index_or_length = res_r.index_or_length;

  `SPD_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid_r)
  `SPD_ASSERT(a_data_count_in_range, clk, rst_n, (phase_r == PH_DATA) |-> (byte_cnt_r < pay_len_r))
  `SPD_ASSERT(a_result_from_beat, clk, rst_n, $rose(out_valid_r) |-> $past(acc && res_vld))

endmodule

[test/sync_packet_deframer_checker.sv]
// Scoreboard for sync_packet_deframer: watches the byte, result and register ports,
// tracks frame state, and compares every result beat with the predicted one.
// Depends on spd_pkg.
`timescale 1ns / 100ps

module sync_packet_deframer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [spd_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [spd_pkg::KIND_W-1:0]    out_kind,
  input  logic [spd_pkg::BYTE_W-1:0]    out_data_byte,
  input  logic [spd_pkg::BYTE_W-1:0]    out_msg_id,
  input  logic [spd_pkg::LEN_W-1:0]     out_index_or_length,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                            mismatches,
  output int                            outstanding
);
  import spd_pkg::*;

  logic [BYTE_W-1:0] sync_a_q, sync_b_q;
  logic [LEN_W-1:0]  len_limit;

  phase_t            ph;
  logic [BYTE_W-1:0] id_q, len_lo_q, rx_ck_lo, fa, fb;
  logic [LEN_W-1:0]  frame_len, beat_idx;

  result_t awaited_beats[$];

  initial mismatches = 0;

  function automatic void fletcher_add(logic [BYTE_W-1:0] b);
    fa = fa + b;
    fb = fb + fa;
  endfunction

  function automatic void queue_beat(kind_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] n);
    result_t r;
    r.kind            = k;
    r.data_byte       = d;
    r.msg_id          = id_q;
    r.index_or_length = n;
    awaited_beats.push_back(r);
  endfunction

  function automatic void flag_error(string detail);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, detail);
  endfunction

  function automatic void track_frame(logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    case (ph)
      PH_SYNC1: begin
        beat_idx = '0;
        if (b == sync_a_q) ph = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == sync_b_q) ph = PH_ID;
        else if (b != sync_a_q) ph = PH_SYNC1;
      end
      PH_ID: begin
        id_q = b;
        fa   = '0;
        fb   = '0;
        fletcher_add(b);
        ph   = PH_LENLO;
      end
      PH_LENLO: begin
        len_lo_q = b;
        fletcher_add(b);
        ph = PH_LENHI;
      end
      PH_LENHI: begin
        fletcher_add(b);
        n         = {b, len_lo_q};
        frame_len = n;
        beat_idx  = '0;
        if (n > len_limit) begin
          ph = PH_SYNC1;
          queue_beat(KIND_TOOLONG, '0, n);
        end else if (n == '0) begin
          ph = PH_CKLO;
        end else begin
          ph = PH_DATA;
        end
      end
      PH_DATA: begin
        fletcher_add(b);
        queue_beat(KIND_DATA, b, beat_idx);
        beat_idx = beat_idx + 1'b1;
        if (beat_idx >= frame_len) ph = PH_CKLO;
      end
      PH_CKLO: begin
        rx_ck_lo = b;
        ph = PH_CKHI;
      end
      default: begin
        ph = PH_SYNC1;
        if (rx_ck_lo == fa && b == fb) queue_beat(KIND_GOOD, '0, frame_len);
        else queue_beat(KIND_BADSUM, '0, frame_len);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      sync_a_q  = '0;
      sync_b_q  = '0;
      len_limit = MAX_LEN_RST;
      ph        = PH_SYNC1;
      id_q      = '0;
      len_lo_q  = '0;
      frame_len = '0;
      beat_idx  = '0;
      fa        = '0;
      fb        = '0;
      rx_ck_lo  = '0;
      awaited_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.kind            = kind_t'(out_kind);
        got.data_byte       = out_data_byte;
        got.msg_id          = out_msg_id;
        got.index_or_length = out_index_or_length;
        if (awaited_beats.size() == 0) begin
          flag_error($sformatf("unexpected beat: kind %0d data %02h id %02h idx/len %04h",
                               got.kind, got.data_byte, got.msg_id, got.index_or_length));
        end else begin
          want = awaited_beats.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.msg_id !== want.msg_id ||
              got.index_or_length !== want.index_or_length)
            flag_error($sformatf(
              "beat mismatch (exp/act): kind %0d/%0d data %02h/%02h id %02h/%02h len %04h/%04h",
              want.kind, got.kind, want.data_byte, got.data_byte, want.msg_id,
              got.msg_id, want.index_or_length, got.index_or_length));
        end
      end
      // a byte taken at the same edge as a register write sees the old register value
      if (in_valid && !in_stall) track_frame(in_rx_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:  sync_a_q  = cfg_wdata[BYTE_W-1:0];
          REG_SYNC_SECOND: sync_b_q  = cfg_wdata[BYTE_W-1:0];
          REG_MAX_LEN:     len_limit = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= awaited_beats.size();
  end

endmodule

[test/sync_packet_deframer_tb.sv]
// Testbench top for sync_packet_deframer: clock, reset, register setup, byte stream
// stimulus (framed packets, noise, broken headers) and the verdict.
// Depends on spd_pkg, sync_packet_deframer and sync_packet_deframer_checker.
`timescale 1ns / 100ps

module sync_packet_deframer_tb;
  import spd_pkg::*;

  localparam int               QUIET_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata  = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_data_byte;
  logic [BYTE_W-1:0]    out_msg_id;
  logic [LEN_W-1:0]     out_index_or_length;
  logic                 cfg_ready;

  int mismatches, outstanding;
  int send_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;
  int bytes_sent = 0;

  logic [BYTE_W-1:0] sync_a, sync_b, ck_a, ck_b;
  logic [LEN_W-1:0]  max_len;

  sync_packet_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_msg_id         (out_msg_id),
    .out_index_or_length(out_index_or_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  sync_packet_deframer_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_msg_id         (out_msg_id),
    .out_index_or_length(out_index_or_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles without any accepted beat or register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic put_byte(logic [BYTE_W-1:0] b);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid   <= 1'b0;
      in_rx_byte <= BYTE_W'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic put_summed(logic [BYTE_W-1:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
    put_byte(b);
  endtask

  // sync pair, id, length, payload, Fletcher pair; header only if too long
  task automatic send_frame(logic [BYTE_W-1:0] id, logic [LEN_W-1:0] n, bit spoil);
    ck_a = '0;
    ck_b = '0;
    put_byte(sync_a);
    put_byte(sync_b);
    put_summed(id);
    put_summed(n[7:0]);
    put_summed(n[15:8]);
    if (n > max_len) return;
    for (int i = 0; i < n; i++) put_summed(BYTE_W'($urandom));
    if (spoil) begin
      if ($urandom_range(1)) ck_a ^= BYTE_W'(1 << $urandom_range(7));
      else ck_b ^= BYTE_W'(1 << $urandom_range(7));
    end
    put_byte(ck_a);
    put_byte(ck_b);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] m);
    write_reg(REG_SYNC_FIRST, {BYTE_W'($urandom), a});
    write_reg(REG_SYNC_SECOND, {BYTE_W'($urandom), b});
    write_reg(REG_MAX_LEN, m);
    cfg_valid <= 1'b0;
    sync_a  = a;
    sync_b  = b;
    max_len = m;
  endtask

  // hold off the sender until every result beat is back, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] cap;
    if (max_len != 16'hFFFF && $urandom_range(99) < 10) begin
      if ($urandom_range(3) == 0) return 16'hFFFF;
      return LEN_W'($urandom_range(32'(max_len) + 1, 65535));
    end
    cap = (max_len < 16'd12) ? max_len : 16'd12;
    if ($urandom_range(19) == 0 && max_len >= 16'd64) cap = 16'd64;
    return LEN_W'($urandom_range(0, cap));
  endfunction

  task automatic random_traffic(int budget);
    int start, r;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 12) begin
        repeat ($urandom_range(1, 6)) put_byte(BYTE_W'($urandom));
      end else if (r < 16) begin
        put_byte(sync_a);
        put_byte(BYTE_W'($urandom));
      end else if (r < 19) begin
        put_byte(sync_a);
        put_byte(sync_b);
        put_byte(BYTE_W'($urandom));
      end else begin
        if (r < 24) put_byte(sync_a);
        send_frame(BYTE_W'($urandom), pick_length(), $urandom_range(99) < 20);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      if (p != 0) drain_results();
      if (p == 3) write_reg(REG_SPARE, CFG_DAT_W'($urandom));
      case (p)
        0: set_regs(8'hB5, 8'h62, 16'd1024);
        1: set_regs(8'hAA, 8'hAA, 16'd0);
        2: set_regs(8'hFF, 8'h00, 16'hFFFF);
        3: set_regs(8'h5A, 8'hA5, 16'd7);
        default: set_regs(8'h00, 8'hFF, 16'd300);
      endcase
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 57; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 57; end
        default: begin send_pct = 27; stall_pct = 27; end
      endcase
      if (p == 0) begin
        put_byte(sync_a);
        put_byte(8'h11);                    // stray byte after first sync
        put_byte(sync_a);                   // repeated first sync
        send_frame(8'hFF, 16'd1, 1'b0);
        send_frame(8'h00, 16'd0, 1'b1);     // zero length, bad checksum
        send_frame(8'h7E, 16'hFFFF, 1'b0);  // rejected
        send_frame(8'h01, 16'd1025, 1'b0);  // just over the limit
      end
      random_traffic(150);
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/spd_pkg.sv
rtl/sync_packet_deframer.sv
test/sync_packet_deframer_checker.sv
test/sync_packet_deframer_tb.sv
